// ===== rtl/core/fbm_pkg.sv =====
// Shared types and constants for the file block map table.
// No dependencies; compiled first.
package fbm_pkg;

  localparam int BLOCK_W     = 48;
  localparam int OFF_W       = 12;
  localparam int OUT_OFF_W   = 13;
  localparam int CNT_W       = 7;
  localparam int STAT_W      = 2;
  localparam int CMD_W       = 3;

  localparam int MAP_DEPTH_DEF = 4096;
  localparam int MAX_RUN_DEF   = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_BLOCK = 3'd0,
    CMD_SET_RUN   = 3'd1,
    CMD_LOOKUP    = 3'd2,
    CMD_RANGE     = 3'd3,
    CMD_NEXT      = 3'd4,
    CMD_END       = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_READ,
    S_EVAL,
    S_FIN
  } state_t;

endpackage

// ===== rtl/core/fbm_req_if.sv =====
// Command channel of the file block map table.
// Depends on fbm_pkg.
interface fbm_req_if;
  logic                          valid;
  logic                          ready;
  logic [fbm_pkg::CMD_W-1:0]     command;
  logic [fbm_pkg::OFF_W-1:0]     offset;
  logic [fbm_pkg::BLOCK_W-1:0]   block;
  logic [fbm_pkg::CNT_W-1:0]     count;
  logic                          from_start;

  modport source(output valid, command, offset, block, count, from_start, input ready);
  modport sink(input valid, command, offset, block, count, from_start, output ready);
endinterface

// ===== rtl/core/fbm_rsp_if.sv =====
// Result channel of the file block map table.
// Depends on fbm_pkg.
interface fbm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [fbm_pkg::STAT_W-1:0]      status;
  logic [fbm_pkg::OUT_OFF_W-1:0]   out_offset;
  logic [fbm_pkg::BLOCK_W-1:0]     out_block;
  logic [fbm_pkg::CNT_W-1:0]       run_length;
  logic                            last;

  modport source(output valid, status, out_offset, out_block, run_length, last, input ready);
  modport sink(input valid, status, out_offset, out_block, run_length, last, output ready);
endinterface

// ===== rtl/core/file_block_map_table_unit.sv =====
// Per command, the sequencer steps: set block and set run write their entries in S_WRITE,
// a lookup in range reads the entry (S_READ) and then checks it (S_EVAL), end offset and unknown
// codes go straight to S_FIN, range query and next offset read and check one offset after another.
// One command at a time; the single-port store (one read or write a cycle) sets the pace.
// The result register lets a new command be taken while a result waits.
// Reset (rst, synchronous): a sweep over all MAP_DEPTH entries clears the valid bits; no beat
// is accepted during it.
module file_block_map_table_unit #(
  parameter int MAP_DEPTH = fbm_pkg::MAP_DEPTH_DEF,
  parameter int MAX_RUN   = fbm_pkg::MAX_RUN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fbm_req_if.sink    req,
  fbm_rsp_if.source  rsp
);
  import fbm_pkg::*;

  localparam int AW = $clog2(MAP_DEPTH);
  localparam int PW = (AW + 1 > OUT_OFF_W) ? AW + 1 : OUT_OFF_W;
  localparam int MW = BLOCK_W + 1;

  // entry store: valid bit on top of the block word
  logic [MW-1:0] mem [MAP_DEPTH];
  logic [MW-1:0] rdata;
  logic          mem_we, mem_re;
  logic [MW-1:0] mem_wdata;

  state_t state, state_next;
  logic [PW-1:0]      ptr, base_off, cur_off;
  logic [PW-1:0]      end_mark;
  logic [CNT_W-1:0]   idx, cnt, cur_len;
  logic [CMD_W-1:0]   op;
  logic [BLOCK_W-1:0] blk_cur, cur_blk;
  logic               dropped, have;

  logic [STAT_W-1:0]    res_status;
  logic [OUT_OFF_W-1:0] res_offset;
  logic [BLOCK_W-1:0]   res_block;
  logic [CNT_W-1:0]     res_len;

  logic                 o_valid, o_last;
  logic [STAT_W-1:0]    o_status;
  logic [OUT_OFF_W-1:0] o_offset;
  logic [BLOCK_W-1:0]   o_block;
  logic [CNT_W-1:0]     o_len;

  logic ptr_ok, run_done, hit, merge, out_free, accept, fin_load, ext_load, ext_need;
  logic [BLOCK_W-1:0] rblk;
  logic [CNT_W-1:0]   cnt_sat;

  assign ptr_ok   = ptr < PW'(MAP_DEPTH);
  assign run_done = idx == cnt;
  assign hit      = rdata[BLOCK_W];
  assign rblk     = rdata[BLOCK_W-1:0];
  assign merge    = have && (cur_off + PW'(cur_len) == ptr)
                    && (cur_blk + BLOCK_W'(cur_len) == rblk);
  assign out_free = !o_valid || rsp.ready;
  assign cnt_sat  = (req.count > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : req.count;
  assign accept   = req.valid && req.ready;
  assign ext_need = (state == S_EVAL) && (op == CMD_RANGE) && hit && have && !merge;
  assign ext_load = ext_need && out_free;
  assign fin_load = (state == S_FIN) && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (ptr == PW'(MAP_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (req.valid) begin
          case (req.command)
            CMD_SET_BLOCK, CMD_SET_RUN: state_next = S_WRITE;
            CMD_LOOKUP: state_next = (PW'(req.offset) < PW'(MAP_DEPTH)) ? S_READ : S_FIN;
            CMD_RANGE, CMD_NEXT: state_next = S_READ;
            default: state_next = S_FIN;
          endcase
        end
      end
      S_WRITE: if (run_done) state_next = S_FIN;
      S_READ: begin
        if ((op == CMD_RANGE && run_done) || !ptr_ok) state_next = S_FIN;
        else state_next = S_EVAL;
      end
      S_EVAL: begin
        case (op)
          CMD_NEXT:  state_next = hit ? S_FIN : S_READ;
          CMD_RANGE: state_next = (ext_need && !out_free) ? S_EVAL : S_READ;
          default:   state_next = S_FIN;
        endcase
      end
      S_FIN: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = {1'b1, blk_cur};
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_IDLE:  req.ready = 1'b1;
      S_WRITE: mem_we = !run_done && ptr_ok;
      S_READ:  mem_re = !((op == CMD_RANGE && run_done) || !ptr_ok);
      default: ;
    endcase
  end

  // store access, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[ptr[AW-1:0]] <= mem_wdata;
    if (mem_re) rdata <= mem[ptr[AW-1:0]];
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      ptr      <= '0;
      end_mark <= '0;
      have     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: ptr <= ptr + 1'b1;
        S_IDLE: begin
          if (accept) begin
            op       <= req.command;
            base_off <= PW'(req.offset);
            ptr      <= (req.command == CMD_NEXT) ?
                        (req.from_start ? '0 : PW'(req.offset) + 1'b1) : PW'(req.offset);
            idx      <= '0;
            cnt      <= (req.command == CMD_SET_BLOCK) ? CNT_W'(1) : cnt_sat;
            blk_cur  <= req.block;
            dropped  <= 1'b0;
            have     <= 1'b0;
            res_block <= '0;
            res_len   <= '0;
            case (req.command)
              CMD_LOOKUP: begin
                res_status <= STAT_RANGE;
                res_offset <= OUT_OFF_W'(req.offset);
              end
              CMD_END: begin
                res_status <= (end_mark == '0) ? STAT_NONE : STAT_OK;
                res_offset <= OUT_OFF_W'(end_mark);
              end
              default: begin
                res_status <= STAT_NONE;
                res_offset <= '0;
              end
            endcase
          end
        end
        S_WRITE: begin
          if (run_done) begin
            res_status <= dropped ? STAT_RANGE : STAT_OK;
          end else begin
            if (!ptr_ok) dropped <= 1'b1;
            else if (ptr + 1'b1 > end_mark) end_mark <= ptr + 1'b1;
            ptr     <= ptr + 1'b1;
            idx     <= idx + 1'b1;
            blk_cur <= blk_cur + 1'b1;
          end
        end
        S_READ: begin
          if (op == CMD_RANGE && (run_done || !ptr_ok)) begin
            res_status <= have ? STAT_OK : STAT_NONE;
            res_offset <= OUT_OFF_W'(have ? cur_off : base_off);
            res_block  <= have ? cur_blk : '0;
            res_len    <= have ? cur_len : '0;
          end else if (op == CMD_NEXT && !ptr_ok) begin
            res_status <= STAT_NONE;
            res_offset <= '0;
          end
        end
        S_EVAL: begin
          case (op)
            CMD_LOOKUP: begin
              res_status <= hit ? STAT_OK : STAT_NONE;
              res_block  <= hit ? rblk : '0;
              res_len    <= hit ? CNT_W'(1) : '0;
            end
            CMD_NEXT: begin
              if (hit) begin
                res_status <= STAT_OK;
                res_offset <= OUT_OFF_W'(ptr);
              end else begin
                ptr <= ptr + 1'b1;
              end
            end
            default: begin
              // range query: extend the open extent or start a new one
              if (!(ext_need && !out_free)) begin
                if (hit) begin
                  if (merge) begin
                    cur_len <= cur_len + 1'b1;
                  end else begin
                    have    <= 1'b1;
                    cur_off <= ptr;
                    cur_blk <= rblk;
                    cur_len <= CNT_W'(1);
                  end
                end
                ptr <= ptr + 1'b1;
                idx <= idx + 1'b1;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fin_load || ext_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
    if (fin_load) begin
      o_status <= res_status;
      o_offset <= res_offset;
      o_block  <= res_block;
      o_len    <= res_len;
      o_last   <= 1'b1;
    end else if (ext_load) begin
      o_status <= STAT_OK;
      o_offset <= OUT_OFF_W'(cur_off);
      o_block  <= cur_blk;
      o_len    <= cur_len;
      o_last   <= 1'b0;
    end
  end

  assign rsp.valid      = o_valid;
  assign rsp.status     = o_status;
  assign rsp.out_offset = o_offset;
  assign rsp.out_block  = o_block;
  assign rsp.run_length = o_len;
  assign rsp.last       = o_last;

  // checks
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req.ready) else $error("beat taken during clear sweep");
  a_end_bound: assert property (@(posedge clk) disable iff (rst)
    end_mark <= PW'(MAP_DEPTH)) else $error("end mark past map depth");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    have |-> cur_len <= CNT_W'(MAX_RUN)) else $error("extent longer than max run");
  a_ext_not_last: assert property (@(posedge clk) disable iff (rst)
    ext_load |=> rsp.valid && !rsp.last) else $error("inner extent marked last");

endmodule
